// ===== rtl/wbcs_pkg.sv =====
package wbcs_pkg;

  localparam int ColW      = 12;
  localparam int SumW      = 36;
  localparam int CountW    = 25;
  localparam int WidthW    = 13;
  localparam int MaxWidth  = 4096;
  localparam int DivSteps  = SumW;
  localparam int StepW     = $clog2(DivSteps);

  localparam logic [WidthW-1:0] ResetWidth = 13'd640;

  // x/3 == (x * Recip3) >> Recip3Shift, exact for x below 2**16
  localparam logic [15:0] Recip3      = 16'd43691;
  localparam int          Recip3Shift = 17;

  typedef enum logic [1:0] {
    CMD_STOP    = 2'd0,
    CMD_LEFT    = 2'd1,
    CMD_RIGHT   = 2'd2,
    CMD_FORWARD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_DIV   = 2'd1,
    BK_WRITE = 2'd2
  } back_state_t;

  // one finished frame, handed from the front to the back
  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] count;
    logic [WidthW-1:0] width;
  } job_t;

  typedef struct packed {
    cmd_t              command;
    logic [ColW-1:0]   centroid;
    logic [CountW-1:0] total;
  } result_t;

endpackage

// ===== rtl/white_blob_centroid_steer_top.sv =====
// Pixels are taken one per clock while full is low; full rises only when two finished frames
// are already waiting for the divider.
// After the frame_end transfer a frame is queued, popped by the back end, run through the
// serial divider and written as a result; a frame with no white pixel skips the divider.
// The back end works on one frame at a time, overlapping the gathering of the next frame.
// Synchronous reset clears counters, queues and state; image_width returns to 640.
module white_blob_centroid_steer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_end,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  command,
  output logic [11:0] centroid_column,
  output logic [24:0] white_total,
  input  logic        image_width_valid,
  output logic        image_width_ready,
  input  logic [12:0] image_width
);

  import wbcs_pkg::*;

  localparam int JobW = $bits(job_t);
  localparam int ResW = $bits(result_t);

  logic    accept;
  logic    job_push;
  logic    job_pop;
  logic    job_empty;
  job_t    job_in;
  job_t    job_out;
  logic    res_push;
  logic    res_full;
  result_t res_in;
  result_t res_out;

  assign image_width_ready = 1'b1;
  assign accept            = push && !full;

  wbcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (image_width_valid && image_width_ready),
    .cfg_data  (image_width),
    .accept    (accept),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .frame_end (frame_end),
    .job_push  (job_push),
    .job       (job_in)
  );

  wbcs_fifo #(
    .WIDTH (JobW),
    .DEPTH (2)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (full),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .empty   (job_empty)
  );

  wbcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .result    (res_in)
  );

  wbcs_fifo #(
    .WIDTH (ResW),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign command         = res_out.command;
  assign centroid_column = res_out.centroid;
  assign white_total     = res_out.total;

endmodule

// ===== rtl/wbcs_fifo.sv =====
module wbcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/wbcs_front.sv =====
module wbcs_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr,
  input  logic [wbcs_pkg::WidthW-1:0] cfg_data,
  input  logic                       accept,
  input  logic [7:0]                 red,
  input  logic [7:0]                 green,
  input  logic [7:0]                 blue,
  input  logic                       frame_end,
  output logic                       job_push,
  output wbcs_pkg::job_t             job
);

  import wbcs_pkg::*;

  logic [WidthW-1:0] width_reg;
  logic [ColW-1:0]   column_index;
  logic [SumW-1:0]   column_sum;
  logic [CountW-1:0] white_count;

  logic [WidthW-1:0] eff_w;
  logic [ColW-1:0]   col_cur;
  logic [WidthW-1:0] col_inc;
  logic [ColW-1:0]   column_index_next;
  logic              is_white;
  logic [SumW:0]     sum_add;
  logic [SumW-1:0]   column_sum_next;
  logic [CountW-1:0] white_count_next;

  always_comb begin
    if (width_reg == '0) begin
      eff_w = WidthW'(1);
    end else if (width_reg > WidthW'(MaxWidth)) begin
      eff_w = WidthW'(MaxWidth);
    end else begin
      eff_w = width_reg;
    end
  end

  // wrap first in case the width shrank mid-frame
  assign col_cur  = ({1'b0, column_index} >= eff_w) ? '0 : column_index;
  assign col_inc  = {1'b0, col_cur} + 1'b1;
  assign column_index_next = (col_inc >= eff_w) ? '0 : col_inc[ColW-1:0];

  assign is_white = (&red) && (&green) && (&blue);
  assign sum_add  = {1'b0, column_sum} + (SumW + 1)'(col_cur);

  always_comb begin
    column_sum_next  = column_sum;
    white_count_next = white_count;
    if (is_white) begin
      column_sum_next = sum_add[SumW] ? '1 : sum_add[SumW-1:0];
      if (white_count != '1) begin
        white_count_next = white_count + 1'b1;
      end
    end
  end

  assign job_push  = accept && frame_end;
  assign job.sum   = column_sum_next;
  assign job.count = white_count_next;
  assign job.width = eff_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg    <= ResetWidth;
      column_index <= '0;
      column_sum   <= '0;
      white_count  <= '0;
    end else begin
      if (cfg_wr) begin
        width_reg <= cfg_data;
      end
      if (accept) begin
        if (frame_end) begin
          column_index <= '0;
          column_sum   <= '0;
          white_count  <= '0;
        end else begin
          column_index <= column_index_next;
          column_sum   <= column_sum_next;
          white_count  <= white_count_next;
        end
      end
    end
  end

endmodule

// ===== rtl/wbcs_back.sv =====
module wbcs_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_empty,
  input  wbcs_pkg::job_t    job,
  output logic              job_pop,
  input  logic              res_full,
  output logic              res_push,
  output wbcs_pkg::result_t result
);

  import wbcs_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [SumW-1:0]   quo;
  logic [CountW-1:0] rem;
  logic [CountW-1:0] divisor;
  logic [StepW-1:0]  step;
  logic [ColW-1:0]   third_lo;
  logic [ColW-1:0]   third_hi;
  logic [CountW-1:0] total;

  logic [WidthW+15:0] lo_prod;
  logic [WidthW+16:0] hi_prod;
  logic [CountW:0]    rem_sh;
  logic [CountW+1:0]  diff;
  logic               fits;
  logic [ColW-1:0]    cen;

  assign lo_prod = job.width * Recip3;
  assign hi_prod = {job.width, 1'b0} * Recip3;

  // one restoring division step per cycle
  assign rem_sh = {rem, quo[SumW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor};
  assign fits   = !diff[CountW+1];

  assign cen = (quo[SumW-1:ColW] != '0) ? '1 : quo[ColW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!job_empty) begin
          state_next = (job.count == '0) ? BK_WRITE : BK_DIV;
        end
      end
      BK_DIV: begin
        if (step == StepW'(DivSteps - 1)) begin
          state_next = BK_WRITE;
        end
      end
      BK_WRITE: begin
        if (!res_full) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop         = 1'b0;
    res_push        = 1'b0;
    result.total    = total;
    result.centroid = '0;
    result.command  = CMD_STOP;
    unique case (state)
      BK_IDLE: begin
        job_pop = !job_empty;
      end
      BK_DIV: begin
        job_pop = 1'b0;
      end
      BK_WRITE: begin
        res_push = !res_full;
        if (total != '0) begin
          result.centroid = cen;
          if (cen < third_lo) begin
            result.command = CMD_LEFT;
          end else if (cen > third_hi) begin
            result.command = CMD_RIGHT;
          end else begin
            result.command = CMD_FORWARD;
          end
        end
      end
      default: job_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      quo      <= job.sum;
      rem      <= '0;
      divisor  <= job.count;
      total    <= job.count;
      step     <= '0;
      third_lo <= lo_prod[Recip3Shift +: ColW];
      third_hi <= hi_prod[Recip3Shift +: ColW];
    end else if (state == BK_DIV) begin
      rem  <= fits ? diff[CountW-1:0] : rem_sh[CountW-1:0];
      quo  <= {quo[SumW-2:0], fits};
      step <= step + 1'b1;
    end
  end

endmodule

// ===== rtl/wbcs_checker.sv =====
module wbcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        frame_end,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  command,
  input logic [11:0] centroid_column,
  input logic [24:0] white_total
);

  import wbcs_pkg::*;

  // no result can be waiting straight after reset
  assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // stop carries no centroid and no white pixels
  assert property (@(posedge clk) disable iff (rst)
    (!empty && command == CMD_STOP) |-> (centroid_column == '0 && white_total == '0))
    else $error("stop result with nonzero centroid or total");

  // any steering command needs at least one white pixel
  assert property (@(posedge clk) disable iff (rst)
    (!empty && command != CMD_STOP) |-> (white_total != '0))
    else $error("steering result with no white pixels");

  // the input side only fills up on a frame_end transfer
  assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && frame_end && !full))
    else $error("full rose without a frame_end transfer");

  // a waiting result holds until it is taken
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(command) && $stable(centroid_column)
                          && $stable(white_total)))
    else $error("waiting result changed or vanished");

endmodule

bind white_blob_centroid_steer_top wbcs_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .push            (push),
  .full            (full),
  .frame_end       (frame_end),
  .empty           (empty),
  .pop             (pop),
  .command         (command),
  .centroid_column (centroid_column),
  .white_total     (white_total)
);

// ===== dv/wbcs_checker.sv =====
module wbcs_tb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_end,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  command,
  input  logic [11:0] centroid_column,
  input  logic [24:0] white_total,
  input  logic        image_width_valid,
  input  logic        image_width_ready,
  input  logic [12:0] image_width,
  output int          fail_count,
  output int          outstanding
);

  import wbcs_pkg::*;

  logic [WidthW-1:0] width_reg;
  logic [ColW-1:0]   col_pos;
  logic [SumW-1:0]   col_total;
  logic [CountW-1:0] white_seen;
  result_t           pending_steer[$];
  result_t           want;
  result_t           got;

  function automatic logic [WidthW-1:0] clamp_width(input logic [WidthW-1:0] raw);
    if (raw == '0) return WidthW'(1);
    if (raw > WidthW'(MaxWidth)) return WidthW'(MaxWidth);
    return raw;
  endfunction

  // Advance the column and accumulators by one pixel; queue a steering result on frame end.
  task automatic predict_steer(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic last);
    logic [WidthW-1:0] w;
    logic [WidthW-1:0] col;
    logic [SumW:0]     sum_next;
    logic [SumW-1:0]   mean;
    int unsigned       w_int;
    int unsigned       cen;
    result_t           res;
    w = clamp_width(width_reg);
    col = {1'b0, col_pos};
    // a narrower width set mid-frame wraps the column first
    if (col >= w) col = '0;
    if (r == 8'hFF && g == 8'hFF && b == 8'hFF) begin
      sum_next = {1'b0, col_total} + (SumW + 1)'(col);
      col_total = sum_next[SumW] ? '1 : sum_next[SumW-1:0];
      if (white_seen != '1) white_seen = white_seen + 1'b1;
    end
    col = col + 1'b1;
    if (col >= w) col = '0;
    col_pos = col[ColW-1:0];
    if (last) begin
      res.total = white_seen;
      if (white_seen == '0) begin
        res.command  = CMD_STOP;
        res.centroid = '0;
      end else begin
        mean = col_total / white_seen;
        res.centroid = (mean > 36'd4095) ? '1 : mean[ColW-1:0];
        w_int = 32'(w);
        cen = 32'(res.centroid);
        if (cen < w_int / 3) res.command = CMD_LEFT;
        else if (cen > (w_int * 2) / 3) res.command = CMD_RIGHT;
        else res.command = CMD_FORWARD;
      end
      pending_steer.push_back(res);
      col_pos    = '0;
      col_total  = '0;
      white_seen = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = ResetWidth;
      col_pos    = '0;
      col_total  = '0;
      white_seen = '0;
      pending_steer.delete();
      fail_count = 0;
    end else begin
      // the pixel sees the width held before this edge
      if (push && !full) predict_steer(red, green, blue, frame_end);
      if (image_width_valid && image_width_ready) width_reg = image_width;
      if (pop && !empty) begin
        got.command  = cmd_t'(command);
        got.centroid = centroid_column;
        got.total    = white_total;
        if (pending_steer.size() == 0) begin
          $error("unexpected result transfer: command %0d centroid_column %0d white_total %0d",
                 command, centroid_column, white_total);
          fail_count++;
        end else begin
          want = pending_steer.pop_front();
          if (got.command !== want.command) begin
            $error("command: expected %0d, actual %0d", want.command, command);
            fail_count++;
          end
          if (got.centroid !== want.centroid) begin
            $error("centroid_column: expected %0d, actual %0d", want.centroid, centroid_column);
            fail_count++;
          end
          if (got.total !== want.total) begin
            $error("white_total: expected %0d, actual %0d", want.total, white_total);
            fail_count++;
          end
        end
      end
    end
    outstanding = pending_steer.size();
  end

endmodule

// ===== dv/tb_white_blob_centroid_steer_top.sv =====
module tb_white_blob_centroid_steer_top;
  import wbcs_pkg::*;

  localparam int DrainCycles   = 48;
  localparam int HoldCycles    = 1500;
  localparam int WatchdogLimit = 20000;
  localparam int RandomItems   = 2000;
  localparam int Phases        = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic        frame_end = 1'b0;
  logic        pop = 1'b0;
  logic        image_width_valid = 1'b0;
  logic [12:0] image_width = 13'd640;
  logic        image_width_ready;
  logic        full;
  logic        empty;
  logic [1:0]  command;
  logic [11:0] centroid_column;
  logic [24:0] white_total;

  int fail_count;
  int outstanding;
  int pixels_sent   = 0;
  int send_idle_pct = 10;
  int recv_idle_pct = 10;
  int holds_asked   = 0;
  int quiet_cycles  = 0;

  always #6 clk = ~clk;

  white_blob_centroid_steer_top DUT (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .red               (red),
    .green             (green),
    .blue              (blue),
    .frame_end         (frame_end),
    .empty             (empty),
    .pop               (pop),
    .command           (command),
    .centroid_column   (centroid_column),
    .white_total       (white_total),
    .image_width_valid (image_width_valid),
    .image_width_ready (image_width_ready),
    .image_width       (image_width)
  );

  wbcs_tb_checker steer_check (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .red               (red),
    .green             (green),
    .blue              (blue),
    .frame_end         (frame_end),
    .empty             (empty),
    .pop               (pop),
    .command           (command),
    .centroid_column   (centroid_column),
    .white_total       (white_total),
    .image_width_valid (image_width_valid),
    .image_width_ready (image_width_ready),
    .image_width       (image_width),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    red       <= r;
    green     <= g;
    blue      <= b;
    frame_end <= last;
    do @(posedge clk); while (full);
    pixels_sent++;
  endtask

  task automatic send_frame(input int len, input int white_pct);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int         pick;
    for (int i = 0; i < len; i++) begin
      pick = int'($urandom_range(99));
      if (pick < white_pct) begin
        {r, g, b} = 24'hFFFFFF;
      end else if (pick < white_pct + 8) begin
        // near white: one channel short of full scale
        {r, g, b} = 24'hFFFFFF;
        case ($urandom_range(2))
          0: r = 8'($urandom_range(254));
          1: g = 8'($urandom_range(254));
          default: b = 8'($urandom_range(254));
        endcase
      end else begin
        {r, g, b} = 24'($urandom);
      end
      send_pixel(r, g, b, i == len - 1);
    end
  endtask

  // Hold the sender until all results are back, then let the back end settle.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_width(input logic [12:0] value);
    wait_drained();
    image_width_valid <= 1'b1;
    image_width       <= value;
    do @(posedge clk); while (!image_width_ready);
    image_width_valid <= 1'b0;
  endtask

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  initial begin : result_side
    int holds_seen;
    int stall_left;
    holds_seen = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_seen) begin
        holds_seen = holds_asked;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (image_width_valid && image_width_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [12:0] w;
    int          target;
    int          len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset width: empty frame gives stop, lone white at column 0 goes left
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFE, 1'b0);
    send_pixel(8'hFE, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFE, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

    // width 4: column 3 steers right, column 1 sits on the lower third and goes forward
    write_width(13'd4);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

    // zero width behaves as one column
    write_width(13'd0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

    // oversize width clamps to the maximum
    write_width(13'h1FFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

    // narrow the width mid-frame so the column wraps before the next pixel
    write_width(13'd8);
    repeat (5) send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    write_width(13'd4);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: w = 13'd5;
        1: w = 13'd1;
        2: w = 13'd4096;
        3: w = 13'd3;
        4: w = 13'($urandom_range(2, 64));
        default: w = 13'($urandom_range(1, 8191));
      endcase
      write_width(w);
      send_idle_pct = (ph == 2) ? 0 : 10;
      recv_idle_pct = (ph == 2) ? 0 : 10;
      if (ph == 3) begin
        // short frames against a stalled result side fill the block
        holds_asked++;
        for (int k = 0; k < 150; k++) send_frame(int'($urandom_range(1, 3)), 50);
      end
      target = pixels_sent + RandomItems / Phases;
      while (pixels_sent < target) begin
        len = ($urandom_range(19) == 0) ? int'($urandom_range(31, 200))
                                        : int'($urandom_range(1, 30));
        send_frame(len, int'($urandom_range(0, 4)) * 25);
      end
    end

    wait_drained();
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wbcs_pkg.sv
rtl/wbcs_fifo.sv
rtl/wbcs_front.sv
rtl/wbcs_back.sv
rtl/white_blob_centroid_steer_top.sv
rtl/wbcs_checker.sv
dv/wbcs_checker.sv
dv/tb_white_blob_centroid_steer_top.sv
